@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ hdl/spa_pkg.sv @@
// ----------------------------------------------------------------------------
// spa_pkg
// Types, constants and controller/datapath interface of the segment pool
// allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int LEN_W        = 32;
   localparam int IDX_W        = $clog2(MAX_SEGMENTS);
   localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
   localparam int ENT_W        = LEN_W + 1;
   localparam int CSR_IDX_W    = 1;

   localparam logic [LEN_W-1:0] POOL_SIZE_RST = 32'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY = 1'd1;

   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_FREE   = 2'd1;
   localparam logic [1:0] MODE_REOPEN = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NO_FIT      = 3'd1;
   localparam logic [2:0] ST_TABLE_FULL  = 3'd2;
   localparam logic [2:0] ST_BAD_OFFSET  = 3'd3;
   localparam logic [2:0] ST_OUTSTANDING = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] request_size;
      logic [31:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] granted_offset;
      logic [6:0]  live_allocations;
      logic [31:0] bytes_allocated;
      logic [6:0]  free_gaps;
   } rsp_type;

   typedef enum logic [4:0] {
      FSM_INIT, FSM_IDLE, FSM_DISPATCH, FSM_SCAN_RD, FSM_SCAN_EV, FSM_ALLOC_DEC,
      FSM_SHUP_RD, FSM_SHUP_WR, FSM_SPLIT_TAIL, FSM_SPLIT_HEAD, FSM_NEXT_RD,
      FSM_NEXT_EV, FSM_FREE_APPLY, FSM_SHDN_RD, FSM_SHDN_WR, FSM_FREE_END,
      FSM_DONE
   } fsm_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_REOPEN, OP_LOAD, OP_SCAN_RD, OP_SCAN_EV, OP_ALLOC_EXACT,
      OP_SHUP_SETUP, OP_SHUP_RD, OP_SHUP_WR, OP_SPLIT_TAIL, OP_SPLIT_HEAD,
      OP_NEXT_RD, OP_NEXT_EV, OP_FREE_APPLY, OP_SHDN_RD, OP_SHDN_WR,
      OP_FREE_END, OP_RESULT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       set_status;
      logic [2:0] code;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       req_zero;
      logic       addr_order;
      logic       scan_fit;
      logic       scan_hit;
      logic       scan_last;
      logic       found;
      logic       exact;
      logic       full;
      logic       pick_last;
      logic       up_done;
      logic       shift_none;
      logic       shdn_last;
      logic       has_alloc;
      logic       rsp_free;
   } sts_type;

endpackage

@@ hdl/spa_ram.sv @@
// ----------------------------------------------------------------------------
// spa_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/spa_ctrl.sv @@
// ----------------------------------------------------------------------------
// spa_ctrl
// Sequencer: scans the segment table, then splits, marks or merges entries
// by issuing one datapath command per cycle, holding while a response waits.
// ----------------------------------------------------------------------------
module spa_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  spa_pkg::sts_type sts,
   output spa_pkg::cmd_type cmd
);
   import spa_pkg::*;

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_INIT:     state_in = FSM_IDLE;
         FSM_IDLE:     if (req_valid) state_in = FSM_DISPATCH;
         FSM_DISPATCH: begin
            case (sts.mode)
               MODE_ALLOC:  state_in = sts.req_zero ? FSM_DONE : FSM_SCAN_RD;
               MODE_FREE:   state_in = FSM_SCAN_RD;
               default:     state_in = FSM_DONE;
            endcase
         end
         FSM_SCAN_RD:  state_in = FSM_SCAN_EV;
         FSM_SCAN_EV: begin
            if (sts.mode == MODE_ALLOC) begin
               if ((sts.addr_order && sts.scan_fit) || sts.scan_last)
                  state_in = FSM_ALLOC_DEC;
               else
                  state_in = FSM_SCAN_RD;
            end else begin
               if (sts.scan_hit)
                  state_in = sts.scan_last ? FSM_FREE_APPLY : FSM_NEXT_RD;
               else if (sts.scan_last)
                  state_in = FSM_DONE;
               else
                  state_in = FSM_SCAN_RD;
            end
         end
         FSM_ALLOC_DEC: begin
            if (!sts.found || sts.exact || sts.full)
               state_in = FSM_DONE;
            else if (sts.pick_last)
               state_in = FSM_SPLIT_TAIL;
            else
               state_in = FSM_SHUP_RD;
         end
         FSM_SHUP_RD:    state_in = FSM_SHUP_WR;
         FSM_SHUP_WR:    state_in = sts.up_done ? FSM_SPLIT_TAIL : FSM_SHUP_RD;
         FSM_SPLIT_TAIL: state_in = FSM_SPLIT_HEAD;
         FSM_SPLIT_HEAD: state_in = FSM_DONE;
         FSM_NEXT_RD:    state_in = FSM_NEXT_EV;
         FSM_NEXT_EV:    state_in = FSM_FREE_APPLY;
         FSM_FREE_APPLY: state_in = sts.shift_none ? FSM_FREE_END : FSM_SHDN_RD;
         FSM_SHDN_RD:    state_in = FSM_SHDN_WR;
         FSM_SHDN_WR:    state_in = sts.shdn_last ? FSM_FREE_END : FSM_SHDN_RD;
         FSM_FREE_END:   state_in = FSM_DONE;
         FSM_DONE:       if (sts.rsp_free) state_in = FSM_IDLE;
         default:        state_in = FSM_INIT;
      endcase
   end

   always_comb begin
      cmd = '{op: OP_NONE, set_status: 1'b0, code: ST_OK};
      req_ready = 1'b0;
      case (state_ff)
         FSM_INIT: cmd.op = OP_REOPEN;
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         FSM_DISPATCH: begin
            if (sts.mode == MODE_ALLOC && sts.req_zero) begin
               cmd.set_status = 1'b1;
               cmd.code       = ST_NO_FIT;
            end else if (sts.mode == MODE_REOPEN) begin
               if (sts.has_alloc) begin
                  cmd.set_status = 1'b1;
                  cmd.code       = ST_OUTSTANDING;
               end else begin
                  cmd.op = OP_REOPEN;
               end
            end
         end
         FSM_SCAN_RD: cmd.op = OP_SCAN_RD;
         FSM_SCAN_EV: begin
            cmd.op = OP_SCAN_EV;
            if (sts.mode != MODE_ALLOC && !sts.scan_hit && sts.scan_last) begin
               cmd.set_status = 1'b1;
               cmd.code       = ST_BAD_OFFSET;
            end
         end
         FSM_ALLOC_DEC: begin
            if (!sts.found) begin
               cmd.set_status = 1'b1;
               cmd.code       = ST_NO_FIT;
            end else if (sts.exact) begin
               cmd.op = OP_ALLOC_EXACT;
            end else if (sts.full) begin
               cmd.set_status = 1'b1;
               cmd.code       = ST_TABLE_FULL;
            end else begin
               cmd.op = OP_SHUP_SETUP;
            end
         end
         FSM_SHUP_RD:    cmd.op = OP_SHUP_RD;
         FSM_SHUP_WR:    cmd.op = OP_SHUP_WR;
         FSM_SPLIT_TAIL: cmd.op = OP_SPLIT_TAIL;
         FSM_SPLIT_HEAD: cmd.op = OP_SPLIT_HEAD;
         FSM_NEXT_RD:    cmd.op = OP_NEXT_RD;
         FSM_NEXT_EV:    cmd.op = OP_NEXT_EV;
         FSM_FREE_APPLY: cmd.op = OP_FREE_APPLY;
         FSM_SHDN_RD:    cmd.op = OP_SHDN_RD;
         FSM_SHDN_WR:    cmd.op = OP_SHDN_WR;
         FSM_FREE_END:   cmd.op = OP_FREE_END;
         FSM_DONE:       if (sts.rsp_free) cmd.op = OP_RESULT;
         default:        cmd.op = OP_NONE;
      endcase
   end

endmodule

@@ hdl/spa_dp.sv @@
// ----------------------------------------------------------------------------
// spa_dp
// Segment table, scan registers, counters, config registers and the
// response register of the allocator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spa_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  spa_pkg::req_type                req_data,
   output spa_pkg::rsp_type                rsp_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            csr_we,
   input  logic [spa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spa_pkg::LEN_W-1:0]       csr_wdata,
   input  spa_pkg::cmd_type                cmd,
   output spa_pkg::sts_type                sts
);
   import spa_pkg::*;

   logic [LEN_W-1:0] pool_ff, pool_in;
   logic             policy_ff, policy_in;
   logic [1:0]       mode_ff, mode_in;
   logic [LEN_W-1:0] size_ff, size_in, offset_ff, offset_in;
   logic [IDX_W-1:0] idx_ff, idx_in, pick_ff, pick_in, hit_ff, hit_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in, dst_ff, dst_in;
   logic [CNT_W-1:0] src_ff, src_in;
   logic [LEN_W-1:0] start_ff, start_in, pick_len_ff, pick_len_in;
   logic [LEN_W-1:0] pick_start_ff, pick_start_in, hit_len_ff, hit_len_in;
   logic [LEN_W-1:0] mrg_len_ff, mrg_len_in, prev_len_ff, prev_len_in;
   logic             found_ff, found_in, prev_free_ff, prev_free_in;
   logic             next_free_ff, next_free_in;
   logic [CNT_W-1:0] seg_cnt_ff, seg_cnt_in, alloc_ff, alloc_in, gap_ff, gap_in;
   logic [LEN_W-1:0] total_ff, total_in, granted_ff, granted_in;
   logic [2:0]       status_ff, status_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [ENT_W-1:0] ram_wdata, ram_rdata;
   logic [LEN_W-1:0] rd_len;
   logic             rd_taken;
   logic [CNT_W-1:0] cnt_m1, merge_k, src_new;

   spa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_len   = ram_rdata[LEN_W-1:0];
   assign rd_taken = ram_rdata[LEN_W];
   assign cnt_m1   = seg_cnt_ff - CNT_W'(1);
   assign merge_k  = CNT_W'(prev_free_ff) + CNT_W'(next_free_ff);
   assign src_new  = CNT_W'(hit_ff) + CNT_W'(1) + CNT_W'(next_free_ff);

   always_comb begin
      sts.mode       = mode_ff;
      sts.req_zero   = (size_ff == '0);
      sts.addr_order = !policy_ff;
      sts.scan_fit   = !rd_taken && (rd_len >= size_ff);
      sts.scan_hit   = rd_taken && (start_ff == offset_ff);
      sts.scan_last  = ({1'b0, idx_ff} == cnt_m1);
      sts.found      = found_ff;
      sts.exact      = (pick_len_ff == size_ff);
      sts.full       = (seg_cnt_ff >= CNT_W'(MAX_SEGMENTS));
      sts.pick_last  = ({1'b0, pick_ff} == cnt_m1);
      sts.up_done    = (ptr_ff == pick_ff + IDX_W'(1));
      sts.shift_none = (merge_k == '0) || (src_new >= seg_cnt_ff);
      sts.shdn_last  = (src_ff == cnt_m1);
      sts.has_alloc  = (alloc_ff != '0);
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      ram_raddr = idx_ff;
      case (cmd.op)
         OP_SHUP_RD: ram_raddr = ptr_ff;
         OP_NEXT_RD: ram_raddr = hit_ff + IDX_W'(1);
         OP_SHDN_RD: ram_raddr = src_ff[IDX_W-1:0];
         default:    ram_raddr = idx_ff;
      endcase
   end

   always_comb begin
      pool_in       = pool_ff;
      policy_in     = policy_ff;
      mode_in       = mode_ff;
      size_in       = size_ff;
      offset_in     = offset_ff;
      idx_in        = idx_ff;
      pick_in       = pick_ff;
      hit_in        = hit_ff;
      ptr_in        = ptr_ff;
      dst_in        = dst_ff;
      src_in        = src_ff;
      start_in      = start_ff;
      pick_len_in   = pick_len_ff;
      pick_start_in = pick_start_ff;
      hit_len_in    = hit_len_ff;
      mrg_len_in    = mrg_len_ff;
      prev_len_in   = prev_len_ff;
      found_in      = found_ff;
      prev_free_in  = prev_free_ff;
      next_free_in  = next_free_ff;
      seg_cnt_in    = seg_cnt_ff;
      alloc_in      = alloc_ff;
      gap_in        = gap_ff;
      total_in      = total_ff;
      granted_in    = granted_ff;
      status_in     = status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      ram_waddr     = pick_ff;
      ram_wdata     = ram_rdata;

      if (csr_we) begin
         case (csr_index)
            CSR_POOL_SIZE:  pool_in   = csr_wdata;
            CSR_FIT_POLICY: policy_in = csr_wdata[0];
            default:        pool_in   = pool_ff;
         endcase
      end

      if (cmd.set_status) status_in = cmd.code;

      case (cmd.op)
         OP_REOPEN: begin
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = {1'b0, pool_ff};
            seg_cnt_in = CNT_W'(1);
            alloc_in   = '0;
            gap_in     = CNT_W'(1);
            total_in   = '0;
         end
         OP_LOAD: begin
            mode_in      = req_data.mode;
            size_in      = req_data.request_size;
            offset_in    = req_data.free_offset;
            idx_in       = '0;
            start_in     = '0;
            found_in     = 1'b0;
            prev_free_in = 1'b0;
            next_free_in = 1'b0;
            status_in    = ST_OK;
            granted_in   = '0;
         end
         OP_SCAN_EV: begin
            start_in = start_ff + rd_len;
            idx_in   = idx_ff + IDX_W'(1);
            if (mode_ff == MODE_ALLOC) begin
               if (sts.scan_fit && (!found_ff || (policy_ff && rd_len < pick_len_ff))) begin
                  found_in      = 1'b1;
                  pick_in       = idx_ff;
                  pick_len_in   = rd_len;
                  pick_start_in = start_ff;
               end
            end else if (sts.scan_hit) begin
               hit_in     = idx_ff;
               hit_len_in = rd_len;
               mrg_len_in = rd_len;
            end else begin
               prev_free_in = !rd_taken;
               prev_len_in  = rd_len;
            end
         end
         OP_ALLOC_EXACT: begin
            ram_we     = 1'b1;
            ram_waddr  = pick_ff;
            ram_wdata  = {1'b1, pick_len_ff};
            gap_in     = gap_ff - CNT_W'(1);
            alloc_in   = alloc_ff + CNT_W'(1);
            total_in   = total_ff + size_ff;
            granted_in = pick_start_ff;
         end
         OP_SHUP_SETUP: ptr_in = cnt_m1[IDX_W-1:0];
         OP_SHUP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff + IDX_W'(1);
            ram_wdata = ram_rdata;
            ptr_in    = ptr_ff - IDX_W'(1);
         end
         OP_SPLIT_TAIL: begin
            ram_we    = 1'b1;
            ram_waddr = pick_ff + IDX_W'(1);
            ram_wdata = {1'b0, pick_len_ff - size_ff};
         end
         OP_SPLIT_HEAD: begin
            ram_we     = 1'b1;
            ram_waddr  = pick_ff;
            ram_wdata  = {1'b1, size_ff};
            seg_cnt_in = seg_cnt_ff + CNT_W'(1);
            alloc_in   = alloc_ff + CNT_W'(1);
            total_in   = total_ff + size_ff;
            granted_in = pick_start_ff;
         end
         OP_NEXT_EV: begin
            next_free_in = !rd_taken;
            if (!rd_taken) mrg_len_in = mrg_len_ff + rd_len;
         end
         OP_FREE_APPLY: begin
            ram_we   = 1'b1;
            if (prev_free_ff) begin
               ram_waddr = hit_ff - IDX_W'(1);
               ram_wdata = {1'b0, prev_len_ff + mrg_len_ff};
            end else begin
               ram_waddr = hit_ff;
               ram_wdata = {1'b0, mrg_len_ff};
            end
            src_in   = src_new;
            dst_in   = IDX_W'(src_new - merge_k);
            alloc_in = alloc_ff - CNT_W'(1);
            total_in = total_ff - hit_len_ff;
            gap_in   = gap_ff + CNT_W'(1) - merge_k;
         end
         OP_SHDN_WR: begin
            ram_we    = 1'b1;
            ram_waddr = dst_ff;
            ram_wdata = ram_rdata;
            src_in    = src_ff + CNT_W'(1);
            dst_in    = dst_ff + IDX_W'(1);
         end
         OP_FREE_END: seg_cnt_in = seg_cnt_ff - merge_k;
         OP_RESULT: begin
            rsp_in.status           = status_ff;
            rsp_in.granted_offset   = granted_ff;
            rsp_in.live_allocations = 7'(alloc_ff);
            rsp_in.bytes_allocated  = total_ff;
            rsp_in.free_gaps        = 7'(gap_ff);
            rsp_valid_in            = 1'b1;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= POOL_SIZE_RST;
         policy_ff    <= 1'b0;
         seg_cnt_ff   <= CNT_W'(1);
         alloc_ff     <= '0;
         gap_ff       <= CNT_W'(1);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_ff      <= pool_in;
         policy_ff    <= policy_in;
         seg_cnt_ff   <= seg_cnt_in;
         alloc_ff     <= alloc_in;
         gap_ff       <= gap_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      size_ff       <= size_in;
      offset_ff     <= offset_in;
      idx_ff        <= idx_in;
      pick_ff       <= pick_in;
      hit_ff        <= hit_in;
      ptr_ff        <= ptr_in;
      dst_ff        <= dst_in;
      src_ff        <= src_in;
      start_ff      <= start_in;
      pick_len_ff   <= pick_len_in;
      pick_start_ff <= pick_start_in;
      hit_len_ff    <= hit_len_in;
      mrg_len_ff    <= mrg_len_in;
      prev_len_ff   <= prev_len_in;
      found_ff      <= found_in;
      prev_free_ff  <= prev_free_in;
      next_free_ff  <= next_free_in;
      granted_ff    <= granted_in;
      status_ff     <= status_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_CLKD(a_seg_cnt_range, clock, reset, (seg_cnt_ff != '0) && (seg_cnt_ff <= CNT_W'(MAX_SEGMENTS)), "segment count out of range")
   `ASSERT_CLKD(a_table_consistent, clock, reset, (cmd.op == OP_RESULT) |-> (alloc_ff + gap_ff == seg_cnt_ff), "free plus taken segments differ from table size")
   `ASSERT_CLKD(a_total_zero, clock, reset, (alloc_ff == '0) |-> (total_ff == '0), "bytes allocated with no live allocation")

endmodule

@@ hdl/segment_pool_allocator.sv @@
// A scan reads the table entries in order; an allocation that splits a segment
// shifts later entries up, and a free that merges neighbors shifts them down.
// One item is processed at a time; the table RAM's single read port and its
// registered read set the read/evaluate step. A finished beat waits in the output register.
// Reset: synchronous, active high; after reset the INIT state writes table entry 0.
// ----------------------------------------------------------------------------
// segment_pool_allocator
// First-fit / best-fit segment allocator with neighbor coalescing.
// ----------------------------------------------------------------------------
module segment_pool_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  spa_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output spa_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [spa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spa_pkg::LEN_W-1:0]     csr_wdata
);
   import spa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   spa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   spa_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

@@ tb/segment_pool_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_pool_allocator_tb
// Self-checking bench for the segment pool allocator. A behavioral segment
// table predicts every response beat; allocate/free sequences run under both
// fit policies and several pool sizes, with random idling on both channels
// and one long response hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module segment_pool_allocator_tb;
   import spa_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 4 * MAX_SEGMENTS + 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LEN_W-1:0]     csr_wdata = '0;

   always #4 clock = ~clock;

   segment_pool_allocator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow segment table
   logic [31:0] seg_base [MAX_SEGMENTS];
   logic [31:0] seg_len  [MAX_SEGMENTS];
   logic        seg_used [MAX_SEGMENTS];
   int          seg_num;
   logic [6:0]  live_cnt;
   logic [31:0] used_bytes;
   logic [6:0]  gap_cnt;
   logic [31:0] cfg_pool_size;
   logic        cfg_best_fit;

   rsp_type expected_rsp [$];
   int      errors = 0;
   bit      quiet = 1'b0;
   bit      rsp_hold = 1'b0;
   int      idle_cnt = 0;

   function automatic void pool_open();
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
         seg_base[k] = '0; seg_len[k] = '0; seg_used[k] = 1'b0;
      end
      seg_len[0] = cfg_pool_size;
      seg_num = 1; live_cnt = '0; used_bytes = '0; gap_cnt = 7'd1;
   endfunction

   function automatic void seg_remove(int idx);
      for (int k = idx; k < seg_num - 1; k++) begin
         seg_base[k] = seg_base[k+1]; seg_len[k] = seg_len[k+1];
         seg_used[k] = seg_used[k+1];
      end
      seg_num--;
   endfunction

   function automatic rsp_type pool_predict(req_type r);
      rsp_type o;
      int      pick;
      int      i;
      bit      found;
      o = '0;
      o.status = ST_OK;
      if (r.mode == MODE_ALLOC) begin
         found = 1'b0; pick = 0;
         if (r.request_size != 0) begin
            for (i = 0; i < seg_num; i++) begin
               if (seg_used[i] || seg_len[i] < r.request_size) continue;
               if (!cfg_best_fit) begin
                  pick = i; found = 1'b1; break;
               end
               if (!found || seg_len[i] < seg_len[pick]) begin
                  pick = i; found = 1'b1;
               end
            end
         end
         if (!found) o.status = ST_NO_FIT;
         else if (seg_len[pick] == r.request_size) begin
            seg_used[pick] = 1'b1; gap_cnt--;
         end else if (seg_num >= MAX_SEGMENTS) o.status = ST_TABLE_FULL;
         else begin
            for (i = seg_num; i > pick + 1; i--) begin
               seg_base[i] = seg_base[i-1]; seg_len[i] = seg_len[i-1];
               seg_used[i] = seg_used[i-1];
            end
            seg_num++;
            seg_base[pick+1] = seg_base[pick] + r.request_size;
            seg_len[pick+1]  = seg_len[pick] - r.request_size;
            seg_used[pick+1] = 1'b0;
            seg_len[pick]    = r.request_size;
            seg_used[pick]   = 1'b1;
         end
         if (o.status == ST_OK) begin
            live_cnt++; used_bytes += r.request_size;
            o.granted_offset = seg_base[pick];
         end
      end else if (r.mode == MODE_FREE) begin
         for (i = 0; i < seg_num; i++)
            if (seg_used[i] && seg_base[i] == r.free_offset) break;
         if (i >= seg_num) o.status = ST_BAD_OFFSET;
         else begin
            seg_used[i] = 1'b0; live_cnt--; used_bytes -= seg_len[i]; gap_cnt++;
            if (i + 1 < seg_num && !seg_used[i+1]) begin
               seg_len[i] += seg_len[i+1]; seg_remove(i + 1); gap_cnt--;
            end
            if (i > 0 && !seg_used[i-1]) begin
               seg_len[i-1] += seg_len[i]; seg_remove(i); gap_cnt--;
            end
         end
      end else if (r.mode == MODE_REOPEN) begin
         if (live_cnt != 0) o.status = ST_OUTSTANDING;
         else pool_open();
      end
      o.live_allocations = live_cnt;
      o.bytes_allocated  = used_bytes;
      o.free_gaps        = gap_cnt;
      return o;
   endfunction

   // pick a random start of a taken segment, or any value if none
   function automatic logic [31:0] taken_offset();
      int idx [$];
      for (int k = 0; k < seg_num; k++) if (seg_used[k]) idx.push_back(k);
      if (idx.size() == 0) return $urandom;
      return seg_base[idx[$urandom_range(idx.size() - 1)]];
   endfunction

   // valid stays up across back-to-back beats; dropped before an idle burst and in settle
   task automatic send_beat(logic [1:0] mode, logic [31:0] size, logic [31:0] offs);
      req_type r;
      int      gap;
      if (!quiet && $urandom_range(3) == 0) begin
         gap = $urandom_range(14, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.mode = mode; r.request_size = size; r.free_offset = offs;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(pool_predict(r));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_POOL_SIZE) cfg_pool_size = val;
      else cfg_best_fit = val[0];
      @(posedge clock);
   endtask

   task automatic free_all();
      while (live_cnt != 0) send_beat(MODE_FREE, '0, taken_offset());
   endtask

   // response checker and ready driver
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected beat, actual %p", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsp.pop_front();
            if (e !== rsp_data) begin
               $display("%0t: mismatch, expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (rsp_hold) rsp_ready <= 1'b0;
      else if (quiet) rsp_ready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(5) == 0) begin
         stall_left <= $urandom_range(14, 1) - 1;
         rsp_ready  <= 1'b0;
      end else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic test_directed();
      send_beat(MODE_ALLOC, 32'd0, '0);
      send_beat(MODE_ALLOC, 32'd65537, '0);
      send_beat(MODE_ALLOC, 32'd100, '0);
      send_beat(MODE_ALLOC, 32'd200, '0);
      send_beat(MODE_ALLOC, 32'd300, '0);
      send_beat(MODE_REOPEN, '0, '0);
      send_beat(MODE_FREE, '0, 32'd100);
      send_beat(MODE_FREE, '0, 32'd100);
      send_beat(MODE_FREE, '0, 32'd600);
      send_beat(MODE_FREE, '0, 32'hFFFF_FFFF);
      send_beat(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(MODE_FREE, '0, 32'd0);
      send_beat(MODE_FREE, '0, 32'd300);
      send_beat(MODE_ALLOC, 32'd65536, '0);
      send_beat(MODE_FREE, '0, 32'd0);
      send_beat(MODE_ALLOC, 32'hFFFF_FFFF, '0);
      send_beat(MODE_REOPEN, '0, '0);
   endtask

   task automatic test_extreme_pools();
      settle();
      csr_write(CSR_POOL_SIZE, 32'hFFFF_FFFF);
      send_beat(MODE_REOPEN, '0, '0);
      send_beat(MODE_ALLOC, 32'hFFFF_FFFF, '0);
      send_beat(MODE_FREE, '0, 32'd0);
      send_beat(MODE_ALLOC, 32'h8000_0000, '0);
      free_all();
      settle();
      csr_write(CSR_POOL_SIZE, 32'd0);
      send_beat(MODE_REOPEN, '0, '0);
      send_beat(MODE_ALLOC, 32'd1, '0);
      settle();
      csr_write(CSR_POOL_SIZE, 32'd1);
      send_beat(MODE_REOPEN, '0, '0);
      send_beat(MODE_ALLOC, 32'd1, '0);
      send_beat(MODE_ALLOC, 32'd1, '0);
      free_all();
   endtask

   task automatic test_table_full();
      settle();
      csr_write(CSR_POOL_SIZE, 32'd100000);
      csr_write(CSR_FIT_POLICY, 32'd0);
      send_beat(MODE_REOPEN, '0, '0);
      repeat (MAX_SEGMENTS + 2) send_beat(MODE_ALLOC, 32'd3, '0);
      free_all();
   endtask

   task automatic test_backpressure();
      rsp_hold = 1'b1;
      fork
         begin
            repeat (8) send_beat(MODE_ALLOC, 32'd16, '0);
         end
         begin
            repeat (300) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join
      free_all();
   endtask

   task automatic random_phase(int n, logic [31:0] pool, logic best, int max_sz);
      int sel;
      settle();
      csr_write(CSR_POOL_SIZE, pool);
      csr_write(CSR_FIT_POLICY, 32'(best));
      send_beat(MODE_REOPEN, '0, '0);
      repeat (n) begin
         sel = $urandom_range(99);
         if (sel < 50) send_beat(MODE_ALLOC, $urandom_range(max_sz, 1), $urandom);
         else if (sel < 88) send_beat(MODE_FREE, $urandom, taken_offset());
         else if (sel < 92) send_beat(MODE_FREE, $urandom, $urandom);
         else if (sel < 94) send_beat(MODE_ALLOC, $urandom, $urandom);
         else if (sel < 96) send_beat(MODE_REOPEN, $urandom, $urandom);
         else send_beat(2'($urandom_range(3)), $urandom, $urandom);
      end
      free_all();
   endtask

   initial begin
      cfg_pool_size = POOL_SIZE_RST;
      cfg_best_fit  = 1'b0;
      pool_open();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_extreme_pools();
      test_table_full();
      test_backpressure();
      random_phase(250, 32'd4096, 1'b0, 300);
      random_phase(250, 32'd4096, 1'b1, 300);
      random_phase(250, 32'hFFFF_FFFF, 1'b1, 32'h2000_0000);
      random_phase(200, 32'd512, 1'b0, 40);
      quiet = 1'b1;
      random_phase(200, 32'd2000, 1'b1, 100);
      settle();
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
